// ===== hdl/hrd_pkg.sv =====
package hrd_pkg;

  localparam int LineBufBytes = 128;
  localparam int LineW = $clog2(LineBufBytes);

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_START = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_CSIZE  = 3'd2,
    PH_CDATA  = 3'd3,
    PH_CTRAIL = 3'd4,
    PH_FIXED  = 3'd5,
    PH_CLOSE  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_RPC_ERR = 2'd3
  } status_t;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_CAPACITY = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  body_byte;
    logic        byte_valid;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] body_length;
  } out_item_t;

  function automatic logic [7:0] te_char(input logic [4:0] i);
    case (i)
      5'd0: te_char = "t";   5'd1: te_char = "r";   5'd2: te_char = "a";
      5'd3: te_char = "n";   5'd4: te_char = "s";   5'd5: te_char = "f";
      5'd6: te_char = "e";   5'd7: te_char = "r";   5'd8: te_char = "-";
      5'd9: te_char = "e";   5'd10: te_char = "n";  5'd11: te_char = "c";
      5'd12: te_char = "o";  5'd13: te_char = "d";  5'd14: te_char = "i";
      5'd15: te_char = "n";  5'd16: te_char = "g";  5'd17: te_char = ":";
      default: te_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] cl_char(input logic [3:0] i);
    case (i)
      4'd0: cl_char = "c";   4'd1: cl_char = "o";   4'd2: cl_char = "n";
      4'd3: cl_char = "t";   4'd4: cl_char = "e";   4'd5: cl_char = "n";
      4'd6: cl_char = "t";   4'd7: cl_char = "-";   4'd8: cl_char = "l";
      4'd9: cl_char = "e";   4'd10: cl_char = "n";  4'd11: cl_char = "g";
      4'd12: cl_char = "t";  4'd13: cl_char = "h";  4'd14: cl_char = ":";
      default: cl_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] ch_char(input logic [2:0] i);
    case (i)
      3'd0: ch_char = "c"; 3'd1: ch_char = "h"; 3'd2: ch_char = "u";
      3'd3: ch_char = "n"; 3'd4: ch_char = "k"; 3'd5: ch_char = "e";
      3'd6: ch_char = "d";
      default: ch_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] err_char(input logic [2:0] i);
    case (i)
      3'd0: err_char = 8'h22; 3'd1: err_char = "e"; 3'd2: err_char = "r";
      3'd3: err_char = "r";   3'd4: err_char = "o"; 3'd5: err_char = "r";
      3'd6: err_char = 8'h22;
      default: err_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] res_char(input logic [2:0] i);
    case (i)
      3'd0: res_char = 8'h22; 3'd1: res_char = "r"; 3'd2: res_char = "e";
      3'd3: res_char = "s";   3'd4: res_char = "u"; 3'd5: res_char = "l";
      3'd6: res_char = "t";   3'd7: res_char = 8'h22;
      default: res_char = 8'h00;
    endcase
  endfunction

endpackage

// ===== hdl/hrd_num.sv =====
// atoi / strtol style accumulator, one character per call
module hrd_num (
  input  logic        hex,
  input  logic [7:0]  c,
  input  logic [1:0]  phase_in,
  input  logic        neg_in,
  input  logic [31:0] value_in,
  input  logic        lone_zero_in,
  output logic [1:0]  phase_out,
  output logic        neg_out,
  output logic [31:0] value_out,
  output logic        lone_zero_out
);
  logic [4:0]  d;
  logic [35:0] v;

  always_comb begin
    phase_out = phase_in;
    neg_out = neg_in;
    value_out = value_in;
    lone_zero_out = lone_zero_in;
    d = 5'd31;
    v = '0;
    if (c >= "0" && c <= "9") d = 5'(c - "0");
    else if (hex && c >= "a" && c <= "f") d = 5'(c - "a" + 8'd10);
    else if (hex && c >= "A" && c <= "F") d = 5'(c - "A" + 8'd10);
    if (phase_in == 2'd3) begin
    end else if (phase_in == 2'd0 &&
                 (c == " " || c == 8'd9 || c == 8'd11 || c == 8'd12)) begin
    end else if (phase_in == 2'd0 && (c == "+" || c == "-")) begin
      neg_out = (c == "-");
      phase_out = 2'd1;
    end else if (hex && phase_in == 2'd2 && lone_zero_in && (c == "x" || c == "X")) begin
      lone_zero_out = 1'b0;
    end else if (d >= (hex ? 5'd16 : 5'd10)) begin
      phase_out = 2'd3;
    end else begin
      if (phase_in != 2'd2) begin
        lone_zero_out = (d == 5'd0);
        phase_out = 2'd2;
      end else begin
        lone_zero_out = 1'b0;
      end
      // value never exceeds 2^31, so shifts stay within 36 bits
      v = hex ? ({4'd0, value_in} << 4) + 36'(d)
              : ({4'd0, value_in} << 3) + ({4'd0, value_in} << 1) + 36'(d);
      value_out = (v > 36'h080000000) ? 32'h80000000 : v[31:0];
    end
  end
endmodule

// ===== hdl/http_response_deframer_top.sv =====
// HTTP/1.1 response deframer: one item (byte, tick, close or start) is taken
// per clock while in_stall is low; its state update and result are computed
// in a single pass of matchers and accumulators into an output register, so
// the sustained rate is one item per cycle while in_stall is low.
// At most one result per item; a skid register behind the output register
// holds one more result, so in_stall rises only while both hold a result and
// drops after the first edge at which out_stall is low.
module http_response_deframer_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  hrd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hrd_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);
  import hrd_pkg::*;

  logic [31:0] timeout_ticks;
  logic [16:0] body_capacity;

  phase_t      phase, phase_next;
  logic [LineW-1:0] line_length, line_length_next;
  logic        enc_ok, enc_ok_next, len_ok, len_ok_next;
  logic [2:0]  ch_pos, ch_pos_next;
  logic        chunked_seen, chunked_seen_next;
  logic [1:0]  num_phase, num_phase_next;
  logic        num_neg, num_neg_next;
  logic [31:0] num_value, num_value_next;
  logic        lone_zero, lone_zero_next;
  logic [31:0] content_length, content_length_next;
  logic [31:0] bytes_remaining, bytes_remaining_next;
  logic [16:0] kept_count, kept_count_next;
  logic [31:0] tick_count, tick_count_next;
  logic [2:0]  err_pos, err_pos_next;
  logic        err_seen, err_seen_next;
  logic [3:0]  res_pos, res_pos_next;
  logic        res_seen, res_seen_next;

  logic        out_full, skid_full;
  out_item_t   skid;
  logic        res_go;
  out_item_t   res;

  logic        take;
  logic [7:0]  c, lc;
  logic        hex;
  logic [1:0]  nf_phase;
  logic        nf_neg, nf_lz;
  logic [31:0] nf_value;
  logic [31:0] num_res;
  logic [16:0] cap;
  logic        kept;
  logic [2:0]  ep;
  logic [3:0]  rp;

  assign take = in_valid && !in_stall;
  assign in_stall = skid_full;
  assign c = in_data.data_byte;
  assign lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  assign hex = (phase == PH_CSIZE);
  assign num_res = num_neg ? (32'd0 - num_value)
                 : (num_value > 32'h7fffffff ? 32'h7fffffff : num_value);
  assign cap = (body_capacity > 17'd65536) ? 17'd65536 : body_capacity;

  hrd_num u_num (
    .hex(hex), .c(c), .phase_in(num_phase), .neg_in(num_neg), .value_in(num_value),
    .lone_zero_in(lone_zero), .phase_out(nf_phase), .neg_out(nf_neg),
    .value_out(nf_value), .lone_zero_out(nf_lz)
  );

  always_comb begin
    phase_next = phase;
    line_length_next = line_length;
    enc_ok_next = enc_ok;
    len_ok_next = len_ok;
    ch_pos_next = ch_pos;
    chunked_seen_next = chunked_seen;
    num_phase_next = num_phase;
    num_neg_next = num_neg;
    num_value_next = num_value;
    lone_zero_next = lone_zero;
    content_length_next = content_length;
    bytes_remaining_next = bytes_remaining;
    kept_count_next = kept_count;
    tick_count_next = tick_count;
    err_pos_next = err_pos;
    err_seen_next = err_seen;
    res_pos_next = res_pos;
    res_seen_next = res_seen;
    res_go = 1'b0;
    res = '0;
    kept = 1'b0;
    ep = 3'd0;
    rp = 4'd0;

    // body keep logic (used by data phases)
    if (cap != 17'd0 && kept_count < cap - 17'd1) begin
      kept = 1'b1;
      if (c == err_char(err_pos)) begin
        ep = err_pos + 3'd1;
        if (ep >= 3'd7) ep = 3'd0;
      end else begin
        ep = (c == 8'h22) ? 3'd1 : 3'd0;
      end
      if (c == res_char(res_pos[2:0])) begin
        rp = res_pos + 4'd1;
        if (rp >= 4'd8) rp = 4'd0;
      end else begin
        rp = (c == 8'h22) ? 4'd1 : 4'd0;
      end
    end

    if (take) begin
      if (in_data.kind == KIND_START) begin
        line_length_next = '0; enc_ok_next = 1'b1; len_ok_next = 1'b1;
        ch_pos_next = '0; num_phase_next = '0; num_neg_next = 1'b0;
        num_value_next = '0; lone_zero_next = 1'b0;
        chunked_seen_next = 1'b0; content_length_next = '1;
        bytes_remaining_next = '0; kept_count_next = '0; tick_count_next = '0;
        err_pos_next = '0; err_seen_next = 1'b0; res_pos_next = '0;
        res_seen_next = 1'b0;
        phase_next = PH_HEADER;
        if (timeout_ticks == 32'd0) begin
          phase_next = PH_IDLE;
          res_go = 1'b1;
          res.done_res = 1'b1;
          res.status = ST_TIMEOUT;
        end
      end else if (phase == PH_IDLE) begin
      end else if (in_data.kind == KIND_TICK) begin
        tick_count_next = (tick_count != 32'hffffffff) ? tick_count + 32'd1 : tick_count;
        if (tick_count_next >= timeout_ticks) begin
          phase_next = PH_IDLE;
          res_go = 1'b1;
          res.done_res = 1'b1;
          if (phase == PH_HEADER) begin
            res.status = ST_TIMEOUT;
          end else begin
            res.body_length = kept_count[15:0];
            res.status = (kept_count == 17'd0) ? ST_EMPTY
                       : (err_seen && !res_seen) ? ST_RPC_ERR : ST_OK;
          end
        end
      end else if (in_data.kind == KIND_CLOSE) begin
        if (phase == PH_CLOSE) begin
          phase_next = PH_IDLE;
          res_go = 1'b1;
          res.done_res = 1'b1;
          res.body_length = kept_count[15:0];
          res.status = (kept_count == 17'd0) ? ST_EMPTY
                     : (err_seen && !res_seen) ? ST_RPC_ERR : ST_OK;
        end
      end else begin
        case (phase)
          PH_HEADER: begin
            if (c == 8'd13) begin
            end else if (c == 8'd10) begin
              if (line_length == '0) begin
                if (chunked_seen) phase_next = PH_CSIZE;
                else if (content_length != 32'd0 && !content_length[31]) begin
                  bytes_remaining_next = content_length;
                  phase_next = PH_FIXED;
                end else phase_next = PH_CLOSE;
              end else if (len_ok && line_length >= LineW'(15)) begin
                content_length_next = num_res;
              end
              line_length_next = '0; enc_ok_next = 1'b1; len_ok_next = 1'b1;
              ch_pos_next = '0; num_phase_next = '0; num_neg_next = 1'b0;
              num_value_next = '0; lone_zero_next = 1'b0;
            end else if (line_length != LineW'(LineBufBytes - 1)) begin
              if (line_length < LineW'(18)) begin
                if (lc != te_char(line_length[4:0])) enc_ok_next = 1'b0;
              end else if (enc_ok) begin
                if (c == ch_char(ch_pos)) begin
                  ch_pos_next = ch_pos + 3'd1;
                  if (ch_pos_next >= 3'd7) begin
                    chunked_seen_next = 1'b1;
                    ch_pos_next = '0;
                  end
                end else begin
                  ch_pos_next = (c == "c") ? 3'd1 : 3'd0;
                end
              end
              if (line_length < LineW'(15)) begin
                if (lc != cl_char(line_length[3:0])) len_ok_next = 1'b0;
              end else if (len_ok) begin
                num_phase_next = nf_phase; num_neg_next = nf_neg;
                num_value_next = nf_value; lone_zero_next = nf_lz;
              end
              line_length_next = line_length + LineW'(1);
            end
          end
          PH_CSIZE: begin
            if (c == 8'd13) begin
            end else if (c == 8'd10) begin
              line_length_next = '0; enc_ok_next = 1'b1; len_ok_next = 1'b1;
              ch_pos_next = '0; num_phase_next = '0; num_neg_next = 1'b0;
              num_value_next = '0; lone_zero_next = 1'b0;
              if (num_res == 32'd0) begin
                phase_next = PH_IDLE;
                res_go = 1'b1;
                res.done_res = 1'b1;
                res.body_length = kept_count[15:0];
                res.status = (kept_count == 17'd0) ? ST_EMPTY
                           : (err_seen && !res_seen) ? ST_RPC_ERR : ST_OK;
              end else if (num_res[31]) begin
                phase_next = PH_CTRAIL;
              end else begin
                bytes_remaining_next = num_res;
                phase_next = PH_CDATA;
              end
            end else if (line_length != LineW'(LineBufBytes - 1)) begin
              num_phase_next = nf_phase; num_neg_next = nf_neg;
              num_value_next = nf_value; lone_zero_next = nf_lz;
              line_length_next = line_length + LineW'(1);
            end
          end
          PH_CTRAIL: begin
            if (c == 8'd10) begin
              line_length_next = '0; enc_ok_next = 1'b1; len_ok_next = 1'b1;
              ch_pos_next = '0; num_phase_next = '0; num_neg_next = 1'b0;
              num_value_next = '0; lone_zero_next = 1'b0;
              phase_next = PH_CSIZE;
            end
          end
          PH_CDATA, PH_FIXED, PH_CLOSE: begin
            if (kept) begin
              kept_count_next = kept_count + 17'd1;
              err_pos_next = ep;
              res_pos_next = rp;
              if (c == err_char(err_pos) && err_pos == 3'd6) err_seen_next = 1'b1;
              if (c == res_char(res_pos[2:0]) && res_pos == 4'd7) res_seen_next = 1'b1;
              res_go = 1'b1;
              res.body_byte = c;
              res.byte_valid = 1'b1;
            end
            if (phase != PH_CLOSE) begin
              bytes_remaining_next = bytes_remaining - 32'd1;
              if (bytes_remaining_next == 32'd0) begin
                if (phase == PH_CDATA) begin
                  phase_next = PH_CTRAIL;
                end else begin
                  phase_next = PH_IDLE;
                  res_go = 1'b1;
                  res.done_res = 1'b1;
                  res.body_length = kept_count_next[15:0];
                  res.status = (kept_count_next == 17'd0) ? ST_EMPTY
                             : (err_seen_next && !res_seen_next) ? ST_RPC_ERR : ST_OK;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= 32'd5000;
      body_capacity <= 17'd2048;
      phase <= PH_IDLE;
      line_length <= '0; enc_ok <= 1'b1; len_ok <= 1'b1; ch_pos <= '0;
      chunked_seen <= 1'b0; num_phase <= '0; num_neg <= 1'b0; num_value <= '0;
      lone_zero <= 1'b0; content_length <= '1; bytes_remaining <= '0;
      kept_count <= '0; tick_count <= '0; err_pos <= '0; err_seen <= 1'b0;
      res_pos <= '0; res_seen <= 1'b0;
      out_full <= 1'b0;
      skid_full <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_TIMEOUT) timeout_ticks <= cfg_data;
        else body_capacity <= cfg_data[16:0];
      end
      phase <= phase_next;
      line_length <= line_length_next; enc_ok <= enc_ok_next; len_ok <= len_ok_next;
      ch_pos <= ch_pos_next; chunked_seen <= chunked_seen_next;
      num_phase <= num_phase_next; num_neg <= num_neg_next;
      num_value <= num_value_next; lone_zero <= lone_zero_next;
      content_length <= content_length_next; bytes_remaining <= bytes_remaining_next;
      kept_count <= kept_count_next; tick_count <= tick_count_next;
      err_pos <= err_pos_next; err_seen <= err_seen_next;
      res_pos <= res_pos_next; res_seen <= res_seen_next;
      // output register with one skid entry behind it
      if (!out_full || !out_stall) begin
        if (skid_full) begin
          out_full <= 1'b1;
          skid_full <= res_go;
        end else begin
          out_full <= res_go;
        end
      end else if (res_go) begin
        skid_full <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_full || !out_stall) begin
      if (skid_full) begin
        out_data <= skid;
        if (res_go) skid <= res;
      end else if (res_go) begin
        out_data <= res;
      end
    end else if (res_go) begin
      skid <= res;
    end
  end

  assign out_valid = out_full;
endmodule

// ===== tb/tb_http_response_deframer_top.sv =====
module tb_http_response_deframer_top;
  import hrd_pkg::*;

  localparam string TeWord = "transfer-encoding:";
  localparam string ClWord = "content-length:";
  localparam string ChWord = "chunked";
  localparam string ErrWord = "\"error\"";
  localparam string ResWord = "\"result\"";
  localparam int LineMax = 127;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_TIMEOUT;
  logic [31:0] cfg_data = '0;

  http_response_deframer_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #(20 * 600000);
    $display("tb_http_response_deframer_top failed");
    $finish;
  end

  // ---------------- deframer predictor ----------------
  logic [31:0] tmo_ticks;
  logic [16:0] capacity;
  phase_t      rsp_phase;
  int unsigned line_len, ch_pos, num_state, err_pos, res_pos;
  bit          te_ok, cl_ok, chunked, num_neg, lone_zero, err_seen, res_seen;
  logic [31:0] num_acc, content_len, remaining, kept_cnt, tick_cnt;

  function automatic void line_restart();
    line_len = 0; te_ok = 1; cl_ok = 1; ch_pos = 0;
    num_state = 0; num_neg = 0; num_acc = '0; lone_zero = 0;
  endfunction

  function automatic void response_restart();
    line_restart();
    chunked = 0; content_len = '1; remaining = '0; kept_cnt = '0; tick_cnt = '0;
    err_pos = 0; err_seen = 0; res_pos = 0; res_seen = 0;
  endfunction

  function automatic void number_char(logic [7:0] c, bit hex);
    int unsigned d;
    logic [63:0] v;
    d = 99;
    if (num_state == 3) return;
    if (num_state == 0 && (c == " " || c == 8'd9 || c == 8'd11 || c == 8'd12)) return;
    if (num_state == 0 && (c == "+" || c == "-")) begin
      num_neg = (c == "-");
      num_state = 1;
      return;
    end
    if (hex && num_state == 2 && lone_zero && (c == "x" || c == "X")) begin
      lone_zero = 0;
      return;
    end
    if (c >= "0" && c <= "9") d = c - "0";
    else if (hex && c >= "a" && c <= "f") d = c - "a" + 10;
    else if (hex && c >= "A" && c <= "F") d = c - "A" + 10;
    if (d >= (hex ? 16 : 10)) begin
      num_state = 3;
      return;
    end
    if (num_state != 2) begin
      lone_zero = (d == 0);
      num_state = 2;
    end else begin
      lone_zero = 0;
    end
    v = 64'(num_acc) * (hex ? 16 : 10) + d;
    if (v > 64'h8000_0000) v = 64'h8000_0000;
    num_acc = v[31:0];
  endfunction

  function automatic logic [31:0] number_value();
    if (num_neg) return 32'd0 - num_acc;
    return (num_acc > 32'h7fff_ffff) ? 32'h7fff_ffff : num_acc;
  endfunction

  function automatic bit keep_body_byte(logic [7:0] c);
    logic [31:0] lim;
    lim = (capacity > 17'd65536) ? 32'd65536 : 32'(capacity);
    if (lim == 0 || kept_cnt >= lim - 1) return 0;
    kept_cnt++;
    if (c == ErrWord[err_pos]) begin
      err_pos++;
      if (err_pos >= 7) begin err_seen = 1; err_pos = 0; end
    end else begin
      err_pos = (c == 8'h22) ? 1 : 0;
    end
    if (c == ResWord[res_pos]) begin
      res_pos++;
      if (res_pos >= 8) begin res_seen = 1; res_pos = 0; end
    end else begin
      res_pos = (c == 8'h22) ? 1 : 0;
    end
    return 1;
  endfunction

  function automatic out_item_t body_done(bit has, logic [7:0] c);
    out_item_t r;
    r = '0;
    r.status = ST_OK;
    if (kept_cnt == 0) r.status = ST_EMPTY;
    else if (err_seen && !res_seen) r.status = ST_RPC_ERR;
    r.body_byte = has ? c : 8'd0;
    r.byte_valid = has;
    r.done_res = 1'b1;
    r.body_length = kept_cnt[15:0];
    rsp_phase = PH_IDLE;
    return r;
  endfunction

  function automatic void header_line_done();
    if (line_len == 0) begin
      if (chunked) rsp_phase = PH_CSIZE;
      else if (content_len != 0 && content_len < 32'h8000_0000) begin
        remaining = content_len;
        rsp_phase = PH_FIXED;
      end else rsp_phase = PH_CLOSE;
    end else if (cl_ok && line_len >= 15) begin
      content_len = number_value();
    end
    line_restart();
  endfunction

  function automatic void header_char(logic [7:0] c);
    logic [7:0] lc;
    int unsigned p;
    p = line_len;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    if (p >= LineMax) return;
    if (p < 18) begin
      if (lc != TeWord[p]) te_ok = 0;
    end else if (te_ok) begin
      if (c == ChWord[ch_pos]) begin
        ch_pos++;
        if (ch_pos >= 7) begin chunked = 1; ch_pos = 0; end
      end else begin
        ch_pos = (c == "c") ? 1 : 0;
      end
    end
    if (p < 15) begin
      if (lc != ClWord[p]) cl_ok = 0;
    end else if (cl_ok) begin
      number_char(c, 0);
    end
    line_len = p + 1;
  endfunction

  // returns 1 when the item yields a result
  function automatic bit deframe_item(in_item_t it, output out_item_t r);
    logic [7:0] c;
    logic [31:0] v;
    bit k;
    r = '0;
    c = it.data_byte;
    if (it.kind == KIND_START) begin
      response_restart();
      rsp_phase = PH_HEADER;
      if (tmo_ticks == 0) begin
        rsp_phase = PH_IDLE;
        r.done_res = 1'b1;
        r.status = ST_TIMEOUT;
        return 1;
      end
      return 0;
    end
    if (rsp_phase == PH_IDLE) return 0;
    if (it.kind == KIND_TICK) begin
      if (tick_cnt != 32'hffff_ffff) tick_cnt++;
      if (tick_cnt < tmo_ticks) return 0;
      if (rsp_phase == PH_HEADER) begin
        rsp_phase = PH_IDLE;
        r.done_res = 1'b1;
        r.status = ST_TIMEOUT;
        return 1;
      end
      r = body_done(0, 8'd0);
      return 1;
    end
    if (it.kind == KIND_CLOSE) begin
      if (rsp_phase == PH_CLOSE) begin
        r = body_done(0, 8'd0);
        return 1;
      end
      return 0;
    end
    case (rsp_phase)
      PH_HEADER: begin
        if (c == 8'h0d) return 0;
        if (c == 8'h0a) header_line_done();
        else header_char(c);
        return 0;
      end
      PH_CSIZE: begin
        if (c == 8'h0d) return 0;
        if (c == 8'h0a) begin
          v = number_value();
          line_restart();
          if (v == 0) begin
            r = body_done(0, 8'd0);
            return 1;
          end
          if (v >= 32'h8000_0000) rsp_phase = PH_CTRAIL;
          else begin
            remaining = v;
            rsp_phase = PH_CDATA;
          end
          return 0;
        end
        if (line_len < LineMax) begin
          number_char(c, 1);
          line_len++;
        end
        return 0;
      end
      PH_CTRAIL: begin
        if (c == 8'h0a) begin
          line_restart();
          rsp_phase = PH_CSIZE;
        end
        return 0;
      end
      PH_CDATA: begin
        k = keep_body_byte(c);
        remaining--;
        if (remaining == 0) rsp_phase = PH_CTRAIL;
      end
      PH_FIXED: begin
        k = keep_body_byte(c);
        remaining--;
        if (remaining == 0) begin
          r = body_done(k, c);
          return 1;
        end
      end
      default: k = keep_body_byte(c);
    endcase
    if (!k) return 0;
    r.body_byte = c;
    r.byte_valid = 1'b1;
    return 1;
  endfunction

  // ---------------- checking ----------------
  out_item_t expected_q[$];
  int errors = 0;
  int results_seen = 0;
  int responses_done = 0;
  int items_sent = 0;

  always @(negedge clk) begin
    out_item_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (out_data.done_res) responses_done++;
      if (expected_q.size() == 0) begin
        $error("unexpected result %h", out_data);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_data.body_byte !== e.body_byte) begin
          $error("body_byte exp %h got %h", e.body_byte, out_data.body_byte); errors++;
        end
        if (out_data.byte_valid !== e.byte_valid) begin
          $error("byte_valid exp %b got %b", e.byte_valid, out_data.byte_valid); errors++;
        end
        if (out_data.done_res !== e.done_res) begin
          $error("done_res exp %b got %b", e.done_res, out_data.done_res); errors++;
        end
        if (out_data.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_data.status); errors++;
        end
        if (out_data.body_length !== e.body_length) begin
          $error("body_length exp %0d got %0d", e.body_length, out_data.body_length);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern: free-running, random, periodic and heavy stretches
  logic [11:0] stall_cyc = '0;
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 1'b1;
    if (rst) out_stall <= 1'b0;
    else begin
      case (stall_cyc[11:10])
        2'd0: out_stall <= 1'b0;
        2'd1: out_stall <= ($urandom_range(0, 3) == 0);
        2'd2: out_stall <= (stall_cyc[3:2] == 2'b11);
        default: out_stall <= ($urandom_range(0, 9) < 6);
      endcase
    end
  end

  // ---------------- driving ----------------
  int burst_left = 0;

  task automatic send_item(in_item_t it, bit known, bit known_has, out_item_t known_res);
    out_item_t r;
    bit has;
    in_valid <= 1'b1;
    in_data <= it;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    items_sent++;
    has = deframe_item(it, r);
    if (known) begin
      if (known_has) expected_q.push_back(known_res);
    end else if (has) begin
      expected_q.push_back(r);
    end
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 25);
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(logic [31:0] tmo, logic [31:0] cap);
    cfg_we <= 1'b1; cfg_index <= CFG_TIMEOUT; cfg_data <= tmo;
    @(posedge clk);
    cfg_index <= CFG_CAPACITY; cfg_data <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    tmo_ticks = tmo;
    capacity = cap[16:0];
    @(posedge clk);
  endtask

  // ---------------- random responses ----------------
  in_item_t stim_q[$];

  task automatic put(kind_t k, logic [7:0] b);
    in_item_t it;
    it.kind = k;
    it.data_byte = b;
    stim_q.push_back(it);
    if ($urandom_range(0, 40) == 0) begin
      it.kind = KIND_TICK;
      stim_q.push_back(it);
    end
  endtask

  task automatic put_str(string s);
    foreach (s[i]) put(KIND_BYTE, s[i]);
  endtask

  function automatic string mix_case(string s);
    string t;
    t = s;
    foreach (t[i])
      if (t[i] >= "a" && t[i] <= "z" && $urandom_range(0, 1)) t[i] = t[i] - 8'd32;
    return t;
  endfunction

  task automatic put_eol();
    if ($urandom_range(0, 2) != 0) put(KIND_BYTE, 8'h0d);
    put(KIND_BYTE, 8'h0a);
  endtask

  function automatic string pad_ws();
    string s, w;
    w = " \t\013\014";
    s = "";
    repeat ($urandom_range(0, 2)) s = {s, string'(w[$urandom_range(0, 3)])};
    return s;
  endfunction

  task automatic put_junk(int n);
    repeat (n) begin
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == 8'h0a) b = 8'h0b;
      put(KIND_BYTE, b);
    end
  endtask

  task automatic put_body_bytes(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: put_str(ErrWord);
        1: put_str(ResWord);
        2: put(KIND_BYTE, 8'h22);
        default: put(KIND_BYTE, 8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic gen_response();
    bit use_chunked;
    int clen_v, sz;
    string s;
    use_chunked = 0;
    clen_v = -1;
    put(KIND_START, 8'($urandom));
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          clen_v = $urandom_range(0, 4) == 0 ? -$urandom_range(0, 5) : $urandom_range(0, 30);
          case ($urandom_range(0, 9))
            0: s = "99999999999";
            1: s = "";
            default: s = $sformatf("%0s%0d", clen_v >= 0 && $urandom_range(0, 3) == 0 ? "+" : "",
                                   clen_v);
          endcase
          put_str({mix_case(ClWord), pad_ws(), s});
          if ($urandom_range(0, 5) == 0) put_str("x1");
        end
        2: begin
          case ($urandom_range(0, 3))
            0: s = " gzip, chunked";
            1: s = " Chunked";
            2: s = "chunkechunked";
            default: s = " chunked";
          endcase
          put_str({mix_case(TeWord), s});
          use_chunked = 1;
        end
        3: put_junk(130 + $urandom_range(0, 10));
        default: put_junk($urandom_range(1, 20));
      endcase
      put_eol();
    end
    put_eol();
    if (use_chunked) begin
      repeat ($urandom_range(0, 3)) begin
        sz = $urandom_range(1, 12);
        if ($urandom_range(0, 7) == 0) begin
          put_str($sformatf("-%0h", sz));
          put_eol();
          put_junk($urandom_range(0, 5));
          put(KIND_BYTE, 8'h0a);
        end else begin
          s = $sformatf("%0h", sz);
          if ($urandom_range(0, 1)) s = mix_case(s);
          if ($urandom_range(0, 3) == 0) s = {$urandom_range(0, 1) ? "0x" : "0X", s};
          put_str({pad_ws(), s});
          if ($urandom_range(0, 4) == 0) put_str(";ext");
          put_eol();
          put_body_bytes(sz);
          put_eol();
        end
      end
      put_str("0");
      put_eol();
      put_eol();
    end else if (clen_v > 0) begin
      put_body_bytes(clen_v);
    end else begin
      put_body_bytes($urandom_range(0, 20));
      put(KIND_CLOSE, 8'($urandom));
    end
    if (tmo_ticks < 100 && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 70)) put(KIND_TICK, 8'($urandom));
    // noise between responses
    repeat ($urandom_range(0, 3)) put(kind_t'($urandom_range(0, 2)), 8'($urandom));
  endtask

  // ---------------- directed table ----------------
  typedef struct {
    kind_t     k;
    logic [7:0] b;
    bit        known;
    bit        has;
    out_item_t res;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic row(kind_t k, logic [7:0] b, bit known = 0, bit has = 0,
                     out_item_t res = '0);
    dir_row_t d;
    d.k = k; d.b = b; d.known = known; d.has = has; d.res = res;
    dir_rows.push_back(d);
  endtask

  localparam int PhaseCount = 8;
  logic [31:0] tmo_set [PhaseCount] = '{32'd0, 32'd1, 32'd3, 32'd40, 32'd200,
                                        32'hffff_ffff, 32'd25, 32'd60};
  logic [31:0] cap_set [PhaseCount] = '{32'd5, 32'd1, 32'd0, 32'd2, 32'd64,
                                        32'd65536, 32'h1ffff, 32'd16};

  initial begin
    int target;
    in_item_t it;
    tmo_ticks = 32'd5000;
    capacity = 17'd2048;
    rsp_phase = PH_IDLE;
    response_restart();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // items while idle give nothing
    row(KIND_BYTE, 8'hff, 1, 0);
    row(KIND_TICK, 8'h00, 1, 0);
    row(KIND_CLOSE, 8'h00, 1, 0);
    // no headers, read until close
    row(KIND_START, 8'h00);
    row(KIND_BYTE, 8'h0a);
    row(KIND_BYTE, 8'h00, 1, 1, '{8'h00, 1'b1, 1'b0, ST_OK, 16'd0});
    row(KIND_BYTE, 8'hff, 1, 1, '{8'hff, 1'b1, 1'b0, ST_OK, 16'd0});
    row(KIND_CLOSE, 8'h00, 1, 1, '{8'h00, 1'b0, 1'b1, ST_OK, 16'd2});
    // empty body
    row(KIND_START, 8'hff);
    row(KIND_BYTE, 8'h0a);
    row(KIND_CLOSE, 8'h00, 1, 1, '{8'h00, 1'b0, 1'b1, ST_EMPTY, 16'd0});
    // error marker without result marker
    row(KIND_START, 8'h00);
    row(KIND_BYTE, 8'h0a);
    foreach (ErrWord[i]) row(KIND_BYTE, ErrWord[i]);
    row(KIND_CLOSE, 8'h00, 1, 1, '{8'h00, 1'b0, 1'b1, ST_RPC_ERR, 16'd7});
    foreach (dir_rows[i]) begin
      it.kind = dir_rows[i].k;
      it.data_byte = dir_rows[i].b;
      send_item(it, dir_rows[i].known, dir_rows[i].has, dir_rows[i].res);
    end
    drain();

    for (int ph = 0; ph < PhaseCount; ph++) begin
      write_config(tmo_set[ph], cap_set[ph]);
      target = items_sent + ((tmo_set[ph] == 0) ? 50 : 215);
      while (items_sent < target) begin
        gen_response();
        while (stim_q.size() != 0) send_item(stim_q.pop_front(), 0, 0, '0);
      end
      drain();
    end

    repeat (10) @(posedge clk);
    $display("run covered %0d items over %0d register settings", items_sent, PhaseCount + 1);
    $display("%0d results checked, %0d responses ended", results_seen, responses_done);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb_http_response_deframer_top passed");
    end else begin
      $display("tb_http_response_deframer_top failed");
    end
    $finish;
  end

endmodule
